// ----- hdl/apf_pkg.sv -----
package apf_pkg;

   localparam int MAX_WIDTH_DEF   = 1024;
   localparam int MAX_WINDOW_DEF  = 16;
   localparam int SAMPLE_BITS_DEF = 16;

   localparam int DIM_W      = 11;
   localparam int WIN_W      = 5;
   localparam int GAIN_W     = 17;
   localparam int GAIN_FRAC  = 16;
   localparam int CSR_DATA_W = 17;
   localparam int CSR_IDX_W  = 3;

   localparam logic [GAIN_W-1:0] GAIN_RESET = 17'd65536;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_IN_WIDTH,
      REG_IN_HEIGHT,
      REG_WIN_WIDTH,
      REG_WIN_HEIGHT,
      REG_OUT_WIDTH,
      REG_OUT_HEIGHT,
      REG_GAIN
   } csr_index_type;

   typedef enum logic [2:0] {
      LIM_IDLE,
      LIM_START,
      LIM_DIV_W,
      LIM_DIV_H,
      LIM_PROD
   } lim_state_type;

   // effective geometry seen by the datapath
   typedef struct packed {
      logic [DIM_W-1:0]  in_width;
      logic [DIM_W-1:0]  in_height;
      logic [WIN_W-1:0]  win_width;
      logic [WIN_W-1:0]  win_height;
      logic [DIM_W-1:0]  out_width;
      logic [DIM_W-1:0]  out_height;
      logic [DIM_W-1:0]  out_span_w;
      logic [DIM_W-1:0]  out_span_h;
      logic [GAIN_W-1:0] gain;
   } limits_type;

endpackage

// ----- hdl/apf_req_if.sv -----
interface apf_req_if #(
   parameter int SAMPLE_BITS = apf_pkg::SAMPLE_BITS_DEF
);
   logic                          valid;
   logic                          ready;
   logic                          map_start;
   logic signed [SAMPLE_BITS-1:0] sample;

   modport source (output valid, output map_start, output sample, input ready);
   modport sink (input valid, input map_start, input sample, output ready);
endinterface

// ----- hdl/apf_rsp_if.sv -----
interface apf_rsp_if #(
   parameter int SAMPLE_BITS = apf_pkg::SAMPLE_BITS_DEF
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] pooled;
   logic                          map_done;

   modport source (output valid, output pooled, output map_done, input ready);
   modport sink (input valid, input pooled, input map_done, output ready);
endinterface

// ----- hdl/apf_csr.sv -----
module apf_csr #(
   parameter int MAX_WIDTH  = apf_pkg::MAX_WIDTH_DEF,
   parameter int MAX_WINDOW = apf_pkg::MAX_WINDOW_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [apf_pkg::CSR_IDX_W-1:0]    csr_idx,
   input  logic [apf_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output apf_pkg::limits_type              lim,
   output logic                             busy
);
   import apf_pkg::*;

   localparam int CNT_W = $clog2(DIM_W);

   logic [DIM_W-1:0]  in_width_ff, in_height_ff, out_width_ff, out_height_ff;
   logic [WIN_W-1:0]  win_width_ff, win_height_ff;
   logic [GAIN_W-1:0] gain_ff;

   logic [DIM_W-1:0]  iw_eff, ih_eff;
   logic [WIN_W-1:0]  ww_eff, wh_eff;

   lim_state_type     state_ff, state_in;
   logic [DIM_W-1:0]  div_dvd_ff;
   logic [WIN_W-1:0]  div_rem_ff;
   logic [CNT_W-1:0]  div_cnt_ff;
   logic [WIN_W-1:0]  divisor;
   logic [WIN_W:0]    rem_sh;
   logic              ge;
   logic [WIN_W:0]    rem_diff;
   logic [WIN_W-1:0]  rem_next;
   logic [DIM_W-1:0]  dvd_step;
   logic              last;

   logic              load_w, load_h, div_run, cap_w, cap_h, prod_en;

   logic [DIM_W-1:0]  ow_ff, oh_ff, span_w_ff, span_h_ff;
   logic [DIM_W+WIN_W-1:0] prod_w, prod_h;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_width_ff   <= DIM_W'(1);
         in_height_ff  <= DIM_W'(1);
         win_width_ff  <= WIN_W'(1);
         win_height_ff <= WIN_W'(1);
         out_width_ff  <= DIM_W'(1);
         out_height_ff <= DIM_W'(1);
         gain_ff       <= GAIN_RESET;
      end else if (csr_we) begin
         case (csr_idx)
            REG_IN_WIDTH:   in_width_ff   <= csr_wdata[DIM_W-1:0];
            REG_IN_HEIGHT:  in_height_ff  <= csr_wdata[DIM_W-1:0];
            REG_WIN_WIDTH:  win_width_ff  <= csr_wdata[WIN_W-1:0];
            REG_WIN_HEIGHT: win_height_ff <= csr_wdata[WIN_W-1:0];
            REG_OUT_WIDTH:  out_width_ff  <= csr_wdata[DIM_W-1:0];
            REG_OUT_HEIGHT: out_height_ff <= csr_wdata[DIM_W-1:0];
            REG_GAIN:       gain_ff       <= csr_wdata[GAIN_W-1:0];
            default: ;
         endcase
      end
   end

   // zero acts as one, oversize acts as the maximum
   always_comb begin
      iw_eff = in_width_ff;
      if (in_width_ff == '0) iw_eff = DIM_W'(1);
      else if (int'(in_width_ff) > MAX_WIDTH) iw_eff = DIM_W'(MAX_WIDTH);
      ih_eff = in_height_ff;
      if (in_height_ff == '0) ih_eff = DIM_W'(1);
      else if (int'(in_height_ff) > MAX_WIDTH) ih_eff = DIM_W'(MAX_WIDTH);
      ww_eff = win_width_ff;
      if (win_width_ff == '0) ww_eff = WIN_W'(1);
      else if (int'(win_width_ff) > MAX_WINDOW) ww_eff = WIN_W'(MAX_WINDOW);
      wh_eff = win_height_ff;
      if (win_height_ff == '0) wh_eff = WIN_W'(1);
      else if (int'(win_height_ff) > MAX_WINDOW) wh_eff = WIN_W'(MAX_WINDOW);
   end

   // restoring divider, one quotient bit per cycle, shared by both axes
   always_comb begin
      divisor  = (state_ff == LIM_DIV_H) ? wh_eff : ww_eff;
      rem_sh   = {div_rem_ff, div_dvd_ff[DIM_W-1]};
      ge       = rem_sh >= {1'b0, divisor};
      rem_diff = rem_sh - {1'b0, divisor};
      rem_next = ge ? rem_diff[WIN_W-1:0] : rem_sh[WIN_W-1:0];
      dvd_step = {div_dvd_ff[DIM_W-2:0], ge};
      last     = div_cnt_ff == CNT_W'(DIM_W - 1);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         LIM_IDLE:  state_in = LIM_IDLE;
         LIM_START: state_in = LIM_DIV_W;
         LIM_DIV_W: if (last) state_in = LIM_DIV_H;
         LIM_DIV_H: if (last) state_in = LIM_PROD;
         LIM_PROD:  state_in = LIM_IDLE;
         default:   state_in = LIM_IDLE;
      endcase
      if (csr_we) state_in = LIM_START;
   end

   always_comb begin
      busy    = state_ff != LIM_IDLE;
      load_w  = state_ff == LIM_START;
      load_h  = (state_ff == LIM_DIV_W) && last;
      div_run = (state_ff == LIM_DIV_W) || (state_ff == LIM_DIV_H);
      cap_w   = (state_ff == LIM_DIV_W) && last;
      cap_h   = (state_ff == LIM_DIV_H) && last;
      prod_en = state_ff == LIM_PROD;
   end

   assign prod_w = ow_ff * ww_eff;
   assign prod_h = oh_ff * wh_eff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= LIM_IDLE;
         ow_ff     <= DIM_W'(1);
         oh_ff     <= DIM_W'(1);
         span_w_ff <= DIM_W'(1);
         span_h_ff <= DIM_W'(1);
      end else begin
         state_ff <= state_in;
         if (cap_w) ow_ff <= (out_width_ff < dvd_step) ? out_width_ff : dvd_step;
         if (cap_h) oh_ff <= (out_height_ff < dvd_step) ? out_height_ff : dvd_step;
         if (prod_en) begin
            span_w_ff <= prod_w[DIM_W-1:0];
            span_h_ff <= prod_h[DIM_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_w) begin
         div_dvd_ff <= iw_eff;
         div_rem_ff <= '0;
         div_cnt_ff <= '0;
      end else if (load_h) begin
         div_dvd_ff <= ih_eff;
         div_rem_ff <= '0;
         div_cnt_ff <= '0;
      end else if (div_run) begin
         div_dvd_ff <= dvd_step;
         div_rem_ff <= rem_next;
         div_cnt_ff <= div_cnt_ff + CNT_W'(1);
      end
   end

   always_comb begin
      lim.in_width   = iw_eff;
      lim.in_height  = ih_eff;
      lim.win_width  = ww_eff;
      lim.win_height = wh_eff;
      lim.out_width  = ow_ff;
      lim.out_height = oh_ff;
      lim.out_span_w = span_w_ff;
      lim.out_span_h = span_h_ff;
      lim.gain       = gain_ff;
   end

endmodule

// ----- hdl/apf_pool.sv -----
module apf_pool #(
   parameter int MAX_WIDTH   = apf_pkg::MAX_WIDTH_DEF,
   parameter int MAX_WINDOW  = apf_pkg::MAX_WINDOW_DEF,
   parameter int SAMPLE_BITS = apf_pkg::SAMPLE_BITS_DEF,
   parameter int COL_W       = SAMPLE_BITS + 2 * $clog2(MAX_WINDOW)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic                          map_start,
   input  logic signed [SAMPLE_BITS-1:0] sample,
   input  logic                          adv,
   input  apf_pkg::limits_type           lim,
   output logic                          sum_valid,
   output logic signed [COL_W-1:0]       sum,
   output logic                          sum_done
);
   import apf_pkg::*;

   localparam int ROW_W  = SAMPLE_BITS + $clog2(MAX_WINDOW);
   localparam int AW     = $clog2(MAX_WIDTH);
   localparam int WPOS_W = ($clog2(MAX_WINDOW) < WIN_W) ? $clog2(MAX_WINDOW) : WIN_W;

   logic [DIM_W-1:0]        col_ff, row_ff, ocol_ff;
   logic [WPOS_W-1:0]       wcol_ff, wrow_ff;
   logic signed [ROW_W-1:0] row_sum_ff;

   logic [DIM_W-1:0]        col_c, row_c, ocol_c, col_in, row_in, ocol_in;
   logic [WPOS_W-1:0]       wcol_c, wrow_c, wcol_in, wrow_in;
   logic signed [ROW_W-1:0] row_sum_c, row_sum_in, s_ext, rs_new;

   logic active, col_end, row_last_win, emit, done, col_wrap, row_wrap;
   logic [AW-1:0] addr0;

   logic signed [COL_W-1:0] col_mem [MAX_WIDTH];
   logic signed [COL_W-1:0] rd_ff;

   logic                    s1_valid_ff, s1_emit_ff, s1_done_ff, s1_add_ff, s1_fwd_ff;
   logic [AW-1:0]           s1_addr_ff;
   logic signed [ROW_W-1:0] s1_rowsum_ff;
   logic signed [COL_W-1:0] fwd_data_ff, prior, total;

   logic                    sum_valid_ff, sum_done_ff;
   logic signed [COL_W-1:0] sum_ff;

   // a map start drops every position before the sample is used
   always_comb begin
      col_c     = map_start ? '0 : col_ff;
      row_c     = map_start ? '0 : row_ff;
      ocol_c    = map_start ? '0 : ocol_ff;
      wcol_c    = map_start ? '0 : wcol_ff;
      wrow_c    = map_start ? '0 : wrow_ff;
      row_sum_c = map_start ? '0 : row_sum_ff;
   end

   always_comb begin
      s_ext        = {{(ROW_W-SAMPLE_BITS){sample[SAMPLE_BITS-1]}}, sample};
      active       = (col_c < lim.out_span_w) && (row_c < lim.out_span_h)
                     && (ocol_c < lim.out_width);
      rs_new       = (wcol_c == '0) ? s_ext : row_sum_c + s_ext;
      col_end      = active && (WIN_W'(wcol_c) >= lim.win_width - WIN_W'(1));
      row_last_win = WIN_W'(wrow_c) >= lim.win_height - WIN_W'(1);
      emit         = col_end && row_last_win;
      done         = (ocol_c == lim.out_width - DIM_W'(1))
                     && (row_c == lim.out_span_h - DIM_W'(1));
      col_wrap     = col_c >= lim.in_width - DIM_W'(1);
      row_wrap     = row_c >= lim.in_height - DIM_W'(1);
      addr0        = AW'(ocol_c);
   end

   always_comb begin
      row_sum_in = row_sum_c;
      wcol_in    = wcol_c;
      ocol_in    = ocol_c;
      col_in     = col_c;
      row_in     = row_c;
      wrow_in    = wrow_c;
      if (active) begin
         row_sum_in = rs_new;
         if (col_end) begin
            wcol_in = '0;
            ocol_in = ocol_c + DIM_W'(1);
         end else begin
            wcol_in = wcol_c + WPOS_W'(1);
         end
      end
      if (col_wrap) begin
         col_in     = '0;
         wcol_in    = '0;
         ocol_in    = '0;
         row_sum_in = '0;
         if (row_wrap) begin
            row_in  = '0;
            wrow_in = '0;
         end else begin
            row_in  = row_c + DIM_W'(1);
            wrow_in = row_last_win ? '0 : wrow_c + WPOS_W'(1);
         end
      end else begin
         col_in = col_c + DIM_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff     <= '0;
         row_ff     <= '0;
         ocol_ff    <= '0;
         wcol_ff    <= '0;
         wrow_ff    <= '0;
         row_sum_ff <= '0;
      end else if (accept) begin
         col_ff     <= col_in;
         row_ff     <= row_in;
         ocol_ff    <= ocol_in;
         wcol_ff    <= wcol_in;
         wrow_ff    <= wrow_in;
         row_sum_ff <= row_sum_in;
      end
   end

   // column partial sums: read when a row closes, written back on advance
   always_ff @(posedge clock) begin
      if (accept && col_end) rd_ff <= col_mem[addr0];
      if (adv && s1_valid_ff) col_mem[s1_addr_ff] <= total;
   end

   always_comb begin
      prior = s1_fwd_ff ? fwd_data_ff : rd_ff;
      total = {{(COL_W-ROW_W){s1_rowsum_ff[ROW_W-1]}}, s1_rowsum_ff}
              + (s1_add_ff ? prior : '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         sum_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff  <= accept && col_end;
         sum_valid_ff <= s1_valid_ff && s1_emit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && col_end) begin
         s1_emit_ff   <= emit;
         s1_done_ff   <= done;
         s1_add_ff    <= wrow_c != '0;
         s1_addr_ff   <= addr0;
         s1_rowsum_ff <= rs_new;
         // same entry still being written back this cycle
         s1_fwd_ff    <= s1_valid_ff && (s1_addr_ff == addr0);
         fwd_data_ff  <= total;
      end
      if (adv) begin
         sum_ff      <= total;
         sum_done_ff <= s1_done_ff;
      end
   end

   assign sum_valid = sum_valid_ff;
   assign sum       = sum_ff;
   assign sum_done  = sum_done_ff;

endmodule

// ----- hdl/apf_scale.sv -----
module apf_scale #(
   parameter int SAMPLE_BITS = apf_pkg::SAMPLE_BITS_DEF,
   parameter int COL_W       = SAMPLE_BITS + 2 * $clog2(apf_pkg::MAX_WINDOW_DEF)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          sum_valid,
   input  logic signed [COL_W-1:0]       sum,
   input  logic                          sum_done,
   input  logic [apf_pkg::GAIN_W-1:0]    gain,
   output logic                          adv,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [SAMPLE_BITS-1:0] pooled,
   output logic                          map_done
);
   import apf_pkg::*;

   localparam int PROD_W = COL_W + GAIN_W + 1;
   localparam int Q_W    = PROD_W - GAIN_FRAC;

   logic signed [PROD_W-1:0]      prod_in, prod_ff;
   logic                          s3_valid_ff, s3_done_ff;
   logic signed [Q_W-1:0]         quo;
   logic signed [SAMPLE_BITS-1:0] sat;
   logic                          pos_ovf, neg_ovf;

   logic                          out_valid_ff, skid_valid_ff;
   logic signed [SAMPLE_BITS-1:0] out_data_ff, skid_data_ff;
   logic                          out_done_ff, skid_done_ff;
   logic                          take, up;

   assign prod_in = sum * $signed({1'b0, gain});

   always_ff @(posedge clock) begin
      if (reset) s3_valid_ff <= 1'b0;
      else if (adv) s3_valid_ff <= sum_valid;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         prod_ff    <= prod_in;
         s3_done_ff <= sum_done;
      end
   end

   // arithmetic shift rounds toward minus infinity
   always_comb begin
      quo     = prod_ff[PROD_W-1:GAIN_FRAC];
      pos_ovf = !quo[Q_W-1] && (|quo[Q_W-2:SAMPLE_BITS-1]);
      neg_ovf = quo[Q_W-1] && !(&quo[Q_W-2:SAMPLE_BITS-1]);
      if (pos_ovf) sat = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      else if (neg_ovf) sat = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      else sat = quo[SAMPLE_BITS-1:0];
   end

   // output register with skid entry
   assign adv  = !skid_valid_ff;
   assign take = out_valid_ff && rsp_ready;
   assign up   = s3_valid_ff && adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (!out_valid_ff || take) begin
            if (skid_valid_ff) begin
               out_valid_ff  <= 1'b1;
               skid_valid_ff <= 1'b0;
            end else begin
               out_valid_ff <= up;
            end
         end else if (up) begin
            skid_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!out_valid_ff || take) begin
         if (skid_valid_ff) begin
            out_data_ff <= skid_data_ff;
            out_done_ff <= skid_done_ff;
         end else begin
            out_data_ff <= sat;
            out_done_ff <= s3_done_ff;
         end
      end else if (up) begin
         skid_data_ff <= sat;
         skid_done_ff <= s3_done_ff;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign pooled    = out_data_ff;
   assign map_done  = out_done_ff;

endmodule

// ----- hdl/average_pool_forward_2d_core.sv -----
// a window's result passes the column-sum stage and the sum, product and output registers
// throughput: one sample per cycle while rsp keeps up and the divider is idle; the column-sum
//   ram is read when a window row closes and written back, forwarded if the next read hits it
// a configuration write holds req ready low while the shared divider derives the output
//   extent (one quotient bit per cycle, width then height) and the spans are registered
// reset is synchronous: config, positions and control clear, column sums are not cleared
module average_pool_forward_2d_core #(
   parameter int MAX_WIDTH   = apf_pkg::MAX_WIDTH_DEF,
   parameter int MAX_WINDOW  = apf_pkg::MAX_WINDOW_DEF,
   parameter int SAMPLE_BITS = apf_pkg::SAMPLE_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   apf_req_if.sink                        req_if,
   apf_rsp_if.source                      rsp_if,
   input  logic                           csr_we,
   input  logic [apf_pkg::CSR_IDX_W-1:0]  csr_idx,
   input  logic [apf_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import apf_pkg::*;

   localparam int COL_W = SAMPLE_BITS + 2 * $clog2(MAX_WINDOW);

   limits_type              lim;
   logic                    busy, adv, accept;
   logic                    sum_valid, sum_done;
   logic signed [COL_W-1:0] sum;

   assign req_if.ready = adv && !busy;
   assign accept       = req_if.valid && req_if.ready;

   apf_csr #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_WINDOW (MAX_WINDOW)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_idx   (csr_idx),
      .csr_wdata (csr_wdata),
      .lim       (lim),
      .busy      (busy)
   );

   apf_pool #(
      .MAX_WIDTH   (MAX_WIDTH),
      .MAX_WINDOW  (MAX_WINDOW),
      .SAMPLE_BITS (SAMPLE_BITS),
      .COL_W       (COL_W)
   ) u_pool (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .map_start (req_if.map_start),
      .sample    (req_if.sample),
      .adv       (adv),
      .lim       (lim),
      .sum_valid (sum_valid),
      .sum       (sum),
      .sum_done  (sum_done)
   );

   apf_scale #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .COL_W       (COL_W)
   ) u_scale (
      .clock     (clock),
      .reset     (reset),
      .sum_valid (sum_valid),
      .sum       (sum),
      .sum_done  (sum_done),
      .gain      (lim.gain),
      .adv       (adv),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .pooled    (rsp_if.pooled),
      .map_done  (rsp_if.map_done)
   );

endmodule

// ----- tb/tb.sv -----
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import apf_pkg::*;

   localparam int STALL_LIMIT = 1000;
   localparam int DRAIN_CYCLES = 8;
   localparam int MAX_IDLE = 13;
   localparam logic signed [15:0] SAMPLE_MAX = 16'sh7FFF;
   localparam logic signed [15:0] SAMPLE_MIN = 16'sh8000;

   typedef struct {
      logic signed [15:0] pooled;
      logic               map_done;
   } pool_out_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   logic [CSR_IDX_W-1:0] csr_idx;
   logic [CSR_DATA_W-1:0] csr_wdata;

   apf_req_if req_if ();
   apf_rsp_if rsp_if ();

   average_pool_forward_2d_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .rsp_if    (rsp_if),
      .csr_we    (csr_we),
      .csr_idx   (csr_idx),
      .csr_wdata (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // register copy and pooling state of the predictor
   logic [DIM_W-1:0]  cfg_in_w, cfg_in_h, cfg_out_w, cfg_out_h;
   logic [WIN_W-1:0]  cfg_win_w, cfg_win_h;
   logic [GAIN_W-1:0] cfg_gain;
   logic signed [23:0] col_acc [MAX_WIDTH_DEF];
   logic signed [19:0] run_sum;
   logic [9:0]  x_pos, y_pos;
   logic [10:0] out_x;
   logic [3:0]  wx, wy;

   pool_out_type pooled_expected [$];
   int mismatches = 0;
   int items_sent = 0;
   int idle_cycles = 0;
   int rx_hold = 0;
   bit tx_quiet = 1'b0;
   bit rx_quiet = 1'b0;

   function automatic int clamp_dim(input int v, input int hi);
      if (v == 0) return 1;
      return (v > hi) ? hi : v;
   endfunction

   function automatic void pool_restart();
      run_sum = '0;
      x_pos = '0;
      y_pos = '0;
      wx = '0;
      wy = '0;
      out_x = '0;
   endfunction

   function automatic void pool_reset();
      cfg_in_w = 1;
      cfg_in_h = 1;
      cfg_win_w = 1;
      cfg_win_h = 1;
      cfg_out_w = 1;
      cfg_out_h = 1;
      cfg_gain = GAIN_RESET;
      foreach (col_acc[i]) col_acc[i] = '0;
      pool_restart();
   endfunction

   function automatic void apply_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] v);
      case (idx)
         REG_IN_WIDTH:   cfg_in_w = v[DIM_W-1:0];
         REG_IN_HEIGHT:  cfg_in_h = v[DIM_W-1:0];
         REG_WIN_WIDTH:  cfg_win_w = v[WIN_W-1:0];
         REG_WIN_HEIGHT: cfg_win_h = v[WIN_W-1:0];
         REG_OUT_WIDTH:  cfg_out_w = v[DIM_W-1:0];
         REG_OUT_HEIGHT: cfg_out_h = v[DIM_W-1:0];
         REG_GAIN:       cfg_gain = v[GAIN_W-1:0];
         default: ;
      endcase
   endfunction

   // floor of sum * gain / 2^16, clipped to the sample range
   function automatic logic signed [15:0] scale_window(input logic signed [23:0] total);
      longint prod;
      prod = longint'(total) * longint'(cfg_gain);
      prod = prod >>> GAIN_FRAC;
      if (prod > longint'(SAMPLE_MAX)) return SAMPLE_MAX;
      if (prod < longint'(SAMPLE_MIN)) return SAMPLE_MIN;
      return prod[15:0];
   endfunction

   function automatic bit pool_predict(input logic start, input logic signed [15:0] s,
                                       output pool_out_type res);
      int iw, ih, ww, wh, ow, oh;
      logic signed [23:0] total;
      bit hit;
      bit used;
      iw = clamp_dim(cfg_in_w, MAX_WIDTH_DEF);
      ih = clamp_dim(cfg_in_h, MAX_WIDTH_DEF);
      ww = clamp_dim(cfg_win_w, MAX_WINDOW_DEF);
      wh = clamp_dim(cfg_win_h, MAX_WINDOW_DEF);
      ow = cfg_out_w;
      oh = cfg_out_h;
      if (ow > iw / ww) ow = iw / ww;
      if (oh > ih / wh) oh = ih / wh;
      if (start) pool_restart();
      hit = 1'b0;
      used = (x_pos < ow * ww) && (y_pos < oh * wh) && (out_x < ow);
      if (used) begin
         if (wx == 0) run_sum = s;
         else run_sum = run_sum + s;
         if (wx >= ww - 1) begin
            total = run_sum;
            if (wy != 0) total = total + col_acc[out_x];
            col_acc[out_x] = total;
            if (wy >= wh - 1) begin
               res.pooled = scale_window(total);
               res.map_done = (out_x == ow - 1) && (y_pos == oh * wh - 1);
               hit = 1'b1;
            end
            wx = '0;
            out_x++;
         end else begin
            wx++;
         end
      end
      if (x_pos >= iw - 1) begin
         x_pos = '0;
         wx = '0;
         out_x = '0;
         run_sum = '0;
         if (y_pos >= ih - 1) begin
            y_pos = '0;
            wy = '0;
         end else begin
            y_pos++;
            wy = (wy >= wh - 1) ? '0 : wy + 1'b1;
         end
      end else begin
         x_pos++;
      end
      return hit;
   endfunction

   function automatic logic signed [15:0] random_sample();
      case ($urandom_range(0, 7))
         0: return SAMPLE_MAX;
         1: return SAMPLE_MIN;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic int random_window_reg();
      case ($urandom_range(0, 19))
         0, 1: return 0;
         2: return $urandom_range(MAX_WINDOW_DEF + 1, 31);
         3, 4: return MAX_WINDOW_DEF;
         default: return $urandom_range(1, 4);
      endcase
   endfunction

   function automatic int random_extent(input int fit);
      case ($urandom_range(0, 9))
         0: return 0;
         1: return $urandom_range(fit + 1, 2047);
         default: return $urandom_range(1, fit);
      endcase
   endfunction

   function automatic int random_gain();
      case ($urandom_range(0, 7))
         0: return 0;
         1: return 131071;
         2: return GAIN_RESET;
         default: return $urandom_range(0, 131071);
      endcase
   endfunction

   task automatic send_sample(input logic start, input logic signed [15:0] value);
      int gap;
      pool_out_type res;
      gap = tx_quiet ? 0 : $urandom_range(0, MAX_IDLE);
      if (gap != 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.map_start <= start;
      req_if.sample <= value;
      do @(posedge clock); while (!req_if.ready);
      if (pool_predict(start, value, res)) pooled_expected = {pooled_expected, res};
      items_sent++;
   endtask

   // wait until every expected result is out, then let the pipeline empty
   task automatic settle();
      req_if.valid <= 1'b0;
      while (pooled_expected.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input int value);
      csr_we <= 1'b1;
      csr_idx <= idx;
      csr_wdata <= value[CSR_DATA_W-1:0];
      @(posedge clock);
      apply_reg(idx, value[CSR_DATA_W-1:0]);
      csr_we <= 1'b0;
      @(posedge clock);
      // extent divider runs after each write
      while (!req_if.ready) @(posedge clock);
   endtask

   task automatic program_geometry(input int iw, input int ih, input int ww, input int wh,
                                   input int ow, input int oh, input int g);
      settle();
      write_reg(REG_IN_WIDTH, iw);
      write_reg(REG_IN_HEIGHT, ih);
      write_reg(REG_WIN_WIDTH, ww);
      write_reg(REG_WIN_HEIGHT, wh);
      write_reg(REG_OUT_WIDTH, ow);
      write_reg(REG_OUT_HEIGHT, oh);
      write_reg(REG_GAIN, g);
   endtask

   task automatic test_reset_values();
      send_sample(1'b1, 16'sd0);
      send_sample(1'b0, -16'sd1);
      send_sample(1'b1, 16'sd1);
   endtask

   // two 2x2 windows of full-scale samples, max gain, with a restart mid-map
   task automatic test_saturation();
      program_geometry(4, 2, 2, 2, 2, 1, 131071);
      for (int pass = 0; pass < 3; pass++) begin
         for (int c = 0; c < 4; c++) begin
            send_sample(pass != 2 && c == 0, (c < 2) ? SAMPLE_MAX : SAMPLE_MIN);
         end
      end
   endtask

   // window width and gain change between the two rows of one map
   task automatic test_mid_map_reconfig();
      program_geometry(4, 2, 2, 2, 2, 1, GAIN_RESET);
      for (int c = 0; c < 4; c++) send_sample(c == 0, random_sample());
      program_geometry(4, 2, 4, 2, 1, 1, 32768);
      for (int c = 0; c < 4; c++) send_sample(1'b0, random_sample());
      // map wraps here without a start marker
      send_sample(1'b0, random_sample());
   endtask

   task automatic test_register_limits();
      program_geometry(0, 0, 0, 0, 5, 5, GAIN_RESET);
      send_sample(1'b1, random_sample());
      // window wider than the row: nothing is pooled
      program_geometry(3, 1, 5, 1, 1, 1, 0);
      send_sample(1'b1, random_sample());
      send_sample(1'b0, random_sample());
      program_geometry(2047, 2047, 31, 31, 2047, 2047, 131071);
      send_sample(1'b1, random_sample());
      send_sample(1'b0, random_sample());
      send_sample(1'b0, random_sample());
   endtask

   task automatic test_backpressure();
      program_geometry(1, 1, 1, 1, 1, 1, random_gain());
      tx_quiet = 1'b1;
      rx_hold = 200;
      for (int k = 0; k < 60; k++) send_sample(1'($urandom), random_sample());
      tx_quiet = 1'b0;
   endtask

   task automatic test_random_maps(input int target);
      int ww_reg, wh_reg, ww, wh, ow_fit, oh_fit, iw, ih, maps;
      bit start;
      while (items_sent < target) begin
         ww_reg = random_window_reg();
         wh_reg = random_window_reg();
         ww = clamp_dim(ww_reg, MAX_WINDOW_DEF);
         wh = clamp_dim(wh_reg, MAX_WINDOW_DEF);
         if (ww * wh > 16) begin
            ow_fit = 1;
            oh_fit = 1;
         end else begin
            ow_fit = $urandom_range(1, 5);
            oh_fit = $urandom_range(1, 4);
         end
         iw = ww * ow_fit + $urandom_range(0, 2);
         ih = wh * oh_fit + $urandom_range(0, 2);
         program_geometry((iw == 1 && $urandom_range(0, 1)) ? 0 : iw,
                          (ih == 1 && $urandom_range(0, 1)) ? 0 : ih,
                          ww_reg, wh_reg,
                          random_extent(iw / ww), random_extent(ih / wh),
                          random_gain());
         tx_quiet = ($urandom_range(0, 3) == 0);
         rx_quiet = ($urandom_range(0, 3) == 0);
         maps = (ww * wh > 16) ? 1 : $urandom_range(1, 3);
         for (int m = 0; m < maps && items_sent < target; m++) begin
            for (int k = 0; k < iw * ih && items_sent < target; k++) begin
               // later maps may follow on without a start marker; rare restarts are noise
               start = (k == 0 && (m == 0 || $urandom_range(0, 1))) ||
                       ($urandom_range(0, 59) == 0);
               send_sample(start, random_sample());
            end
         end
      end
      tx_quiet = 1'b0;
      rx_quiet = 1'b0;
   endtask

   initial begin
      pool_reset();
      reset <= 1'b1;
      req_if.valid <= 1'b0;
      req_if.map_start <= 1'b0;
      req_if.sample <= '0;
      csr_we <= 1'b0;
      csr_idx <= REG_IN_WIDTH;
      csr_wdata <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_reset_values();
      test_saturation();
      test_mid_map_reconfig();
      test_register_limits();
      test_backpressure();
      test_random_maps(850);
      settle();
      if (mismatches == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // result side: random stalls per transfer, plus the long hold when asked
   initial begin
      int stall;
      rsp_if.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (rx_hold > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (rx_hold) @(posedge clock);
            rx_hold = 0;
         end
         stall = rx_quiet ? 0 : $urandom_range(0, MAX_IDLE);
         if (stall != 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_if.valid && rsp_if.ready) && rx_hold == 0);
      end
   end

   always @(posedge clock) begin
      pool_out_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pooled_expected.size() == 0) begin
            $error("pooled: expected none, got %0d", rsp_if.pooled);
            mismatches++;
         end else begin
            want = pooled_expected.pop_front();
            if (rsp_if.pooled !== want.pooled) begin
               $error("pooled: expected %0d, got %0d", want.pooled, rsp_if.pooled);
               mismatches++;
            end
            if (rsp_if.map_done !== want.map_done) begin
               $error("map_done: expected %0b, got %0b", want.map_done, rsp_if.map_done);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) || csr_we) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
